// ----- rtl/gmc_pkg.sv -----
// ----------------------------------------------------------------------------
// gmc_pkg
// types and codes shared by the maze carver modules
// ----------------------------------------------------------------------------
package gmc_pkg;

    localparam logic [1:0] ACT_RESTART = 2'd0;
    localparam logic [1:0] ACT_STEP    = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    localparam logic [2:0] ST_CARVED   = 3'd0;
    localparam logic [2:0] ST_RETIRED  = 3'd1;
    localparam logic [2:0] ST_FINISHED = 3'd2;
    localparam logic [2:0] ST_ALREADY  = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_RDCELL,
        S_RDWAIT,
        S_MOD1,
        S_FRD,
        S_FWAIT,
        S_NREQ,
        S_NWAIT,
        S_MOD2,
        S_CARVE1,
        S_CARVE2,
        S_RET1,
        S_RET2,
        S_RET3,
        S_FIN1,
        S_FIN2,
        S_OUT
    } state_t;

endpackage

// ----- rtl/gmc_modunit.sv -----
// ----------------------------------------------------------------------------
// gmc_modunit
// restoring modulo unit, one quotient bit per cycle over a 16 bit dividend
// ----------------------------------------------------------------------------
module gmc_modunit import gmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [10:0] divisor,
    output logic        busy,
    output logic [10:0] remainder
);

    logic [15:0] rem_reg, rem_next;
    logic [15:0] div_reg, div_next;
    logic [10:0] dsr_reg, dsr_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [16:0] trial;

    assign trial = {rem_reg, div_reg[15]} - {6'd0, dsr_reg};

    always_comb
    begin
        rem_next = rem_reg;
        div_next = div_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = '0;
            div_next = dividend;
            dsr_next = divisor;
            cnt_next = 5'd16;
        end
        else if (cnt_reg != 5'd0)
        begin
            if (!trial[16])
                rem_next = trial[15:0];
            else
                rem_next = {rem_reg[14:0], div_reg[15]};
            div_next = {div_reg[14:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = (cnt_reg != 5'd0);
    assign remainder = rem_reg[10:0];

endmodule

// ----- rtl/grid_maze_carver.sv -----
// ----------------------------------------------------------------------------
// grid_maze_carver
// growing tree maze carver over a square cell grid
// ----------------------------------------------------------------------------
// one input transfer per command on s_axis, one result transfer per command on
// m_axis. action 0 restarts the grid, 1 does one carving step, 2 reads a cell.
// the block takes one command at a time: s_axis_tready is low from acceptance
// until the result has been transferred on m_axis, and high again in the cycle after.
// after a carving step is accepted the block runs two modulo reductions in the
// shared serial divider, the frontier read, the four neighbour reads on the
// single cell memory port and the carve writes, then loads the output register.
// a retiring step runs no second reduction and no carve writes.
// a restart sweeps all GRID_SIZE*GRID_SIZE cells (961 at the default size) of
// the cell memory one cell a cycle, and then answers. reset runs the same sweep
// without a result, and no command is taken until it ends.
// a stalled result simply waits in the output register.
// ----------------------------------------------------------------------------
module grid_maze_carver import gmc_pkg::*;
#(
    parameter int GRID_SIZE      = 31,
    parameter int FRONTIER_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[1:0], rand_pick[17:2], rand_dir[33:18], read_row[39:34],
    // read_col[45:40], zero fill
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], cell_row[8:3], cell_col[14:9], mid_row[20:15],
    // mid_col[26:21], frontier_count[37:27], cell_wall[38], zero fill
    output logic [39:0] m_axis_tdata
);

    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int CW    = $clog2(CELLS);
    localparam int FW    = $clog2(FRONTIER_DEPTH);
    localparam int MID   = ((GRID_SIZE - 2) / 4) * 2 + 2;
    localparam logic [5:0]  G6   = 6'(GRID_SIZE);
    localparam logic [5:0]  MID6 = 6'(MID);
    localparam logic [10:0] FDEP = 11'(FRONTIER_DEPTH);

    logic cell_mem [CELLS];
    logic [11:0] fr_mem [FRONTIER_DEPTH];

    state_t state_reg, state_next;

    logic [15:0] rpick_reg, rpick_next;
    logic [15:0] rdir_reg, rdir_next;
    logic [5:0]  rrow_reg, rrow_next;
    logic [5:0]  rcol_reg, rcol_next;
    logic [10:0] size_reg, size_next;
    logic [10:0] pick_reg, pick_next;
    logic [5:0]  pr_reg, pr_next;
    logic [5:0]  pc_reg, pc_next;
    logic [1:0]  dir_reg, dir_next;
    logic [3:0]  cand_reg, cand_next;
    logic [11:0] last_reg, last_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic [5:0]  clr_row_reg, clr_row_next;
    logic [5:0]  clr_col_reg, clr_col_next;
    logic        inrange_reg, inrange_next;
    logic        mod_started_reg, mod_started_next;
    logic        boot_reg;

    logic [2:0]  status_reg, status_next;
    logic [5:0]  crow_reg, crow_next, ccol_reg, ccol_next;
    logic [5:0]  mrow_reg, mrow_next, mcol_reg, mcol_next;
    logic        wall_reg, wall_next;
    logic        ovalid_reg, ovalid_next;

    // cell memory port
    logic          cwe, cwd;
    logic [CW-1:0] caddr;
    logic          crd_reg;
    // frontier memory port
    logic          fwe;
    logic [FW-1:0] faddr;
    logic [11:0]   fwd;
    logic [11:0]   frd_reg;

    // shared modulo unit
    logic        m_start, m_busy;
    logic [15:0] m_dvd;
    logic [10:0] m_dsr, m_rem;

    gmc_modunit u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (m_start),
        .dividend  (m_dvd),
        .divisor   (m_dsr),
        .busy      (m_busy),
        .remainder (m_rem)
    );

    always_ff @(posedge clk)
    begin
        if (cwe)
            cell_mem[caddr] <= cwd;
        crd_reg <= cell_mem[caddr];
        if (fwe)
            fr_mem[faddr] <= fwd;
        frd_reg <= fr_mem[faddr];
    end

    function automatic logic [CW-1:0] cidx(input logic [5:0] r, input logic [5:0] c);
        cidx = CW'(r * G6 + {6'd0, c});
    endfunction

    // neighbour in direction dir of the picked point
    logic [6:0] nr, nc;
    logic       n_in;
    always_comb
    begin
        nr = {1'b0, pr_reg};
        nc = {1'b0, pc_reg};
        case (dir_reg)
            2'd0:    nr = {1'b0, pr_reg} - 7'd2;
            2'd1:    nc = {1'b0, pc_reg} - 7'd2;
            2'd2:    nr = {1'b0, pr_reg} + 7'd2;
            default: nc = {1'b0, pc_reg} + 7'd2;
        endcase
        n_in = (nr < {1'b0, G6}) && (nc < {1'b0, G6});
    end

    // selected candidate direction from rdir mod k
    logic [2:0] kcnt;
    logic [1:0] chosen;
    logic [1:0] seen;
    always_comb
    begin
        kcnt   = 3'(cand_reg[0]) + 3'(cand_reg[1]) + 3'(cand_reg[2]) + 3'(cand_reg[3]);
        chosen = 2'd0;
        seen   = 2'd0;
        for (int d = 0; d < 4; d++)
        begin
            if (cand_reg[d])
            begin
                if (seen == m_rem[1:0])
                    chosen = 2'(d);
                seen = seen + 2'd1;
            end
        end
    end

    logic [5:0] clr_r, clr_c;
    assign clr_r = clr_row_reg;
    assign clr_c = clr_col_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (s_axis_tvalid)
                begin
                    case (s_axis_tdata[1:0])
                        ACT_RESTART: state_next = S_CLEAR;
                        ACT_READ:    state_next = S_RDCELL;
                        ACT_STEP:    state_next = S_MOD1;
                        default:     state_next = S_OUT;
                    endcase
                end
            // the sweep after reset ends without a result
            S_CLEAR:
                if (clr_reg == CW'(CELLS - 1))
                    state_next = boot_reg ? S_IDLE : S_OUT;
            S_RDCELL: state_next = S_RDWAIT;
            S_RDWAIT: state_next = S_OUT;
            S_MOD1:
                if (size_reg == 11'd0)
                    state_next = S_OUT;
                else if (mod_started_reg && !m_busy)
                    state_next = S_FRD;
            S_FRD:    state_next = S_FWAIT;
            S_FWAIT:  state_next = S_NREQ;
            S_NREQ:   state_next = S_NWAIT;
            S_NWAIT:
                if (dir_reg == 2'd3)
                    state_next = S_MOD2;
                else
                    state_next = S_NREQ;
            S_MOD2:
                if (cand_reg == 4'd0)
                    state_next = S_RET1;
                else if (mod_started_reg && !m_busy)
                    state_next = S_CARVE1;
            S_CARVE1: state_next = S_CARVE2;
            S_CARVE2: state_next = S_OUT;
            S_RET1:   state_next = S_RET2;
            S_RET2:   state_next = S_RET3;
            S_RET3:   state_next = (size_reg == 11'd0) ? S_FIN1 : S_OUT;
            S_FIN1:   state_next = S_FIN2;
            S_FIN2:   state_next = S_OUT;
            S_OUT:    state_next = (ovalid_reg && m_axis_tready) ? S_IDLE : S_OUT;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        rpick_next = rpick_reg; rdir_next = rdir_reg;
        rrow_next = rrow_reg; rcol_next = rcol_reg; size_next = size_reg;
        pick_next = pick_reg; pr_next = pr_reg; pc_next = pc_reg;
        dir_next = dir_reg; cand_next = cand_reg; last_next = last_reg;
        clr_next = clr_reg; clr_row_next = clr_row_reg; clr_col_next = clr_col_reg;
        inrange_next = inrange_reg;
        mod_started_next = mod_started_reg;
        status_next = status_reg; crow_next = crow_reg; ccol_next = ccol_reg;
        mrow_next = mrow_reg; mcol_next = mcol_reg; wall_next = wall_reg;
        ovalid_next = ovalid_reg;
        cwe = 1'b0; cwd = 1'b0; caddr = '0;
        fwe = 1'b0; fwd = '0; faddr = '0;
        m_start = 1'b0; m_dvd = rpick_reg; m_dsr = size_reg;
        s_axis_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    rpick_next = s_axis_tdata[17:2];
                    rdir_next  = s_axis_tdata[33:18];
                    rrow_next  = s_axis_tdata[39:34];
                    rcol_next  = s_axis_tdata[45:40];
                    status_next = ST_DONE;
                    crow_next = '0; ccol_next = '0; mrow_next = '0; mcol_next = '0;
                    wall_next = 1'b0;
                    clr_next = '0;
                    clr_row_next = '0;
                    clr_col_next = '0;
                    mod_started_next = 1'b0;
                    dir_next = 2'd0;
                    cand_next = '0;
                end
            end
            S_CLEAR:
            begin
                cwe   = 1'b1;
                caddr = clr_reg;
                cwd   = !(clr_r == 6'd0 || clr_c == 6'd0 || clr_r == G6 - 6'd1
                          || clr_c == G6 - 6'd1 || (clr_r == MID6 && clr_c == MID6));
                clr_next = clr_reg + CW'(1);
                // row and column of the sweep address
                if (clr_col_reg == G6 - 6'd1)
                begin
                    clr_col_next = '0;
                    clr_row_next = clr_row_reg + 6'd1;
                end
                else
                    clr_col_next = clr_col_reg + 6'd1;
                // frontier entry 0 and the count
                fwe   = (clr_reg == '0);
                faddr = '0;
                fwd   = {MID6, MID6};
                size_next = 11'd1;
            end
            S_RDCELL:
            begin
                inrange_next = (rrow_reg < G6) && (rcol_reg < G6);
                caddr = inrange_next ? cidx(rrow_reg, rcol_reg) : '0;
            end
            S_RDWAIT:
                wall_next = inrange_reg & crd_reg;
            S_MOD1:
            begin
                if (size_reg == 11'd0)
                    status_next = ST_ALREADY;
                else if (!mod_started_reg)
                begin
                    m_start = 1'b1;
                    mod_started_next = 1'b1;
                end
                else if (!m_busy)
                begin
                    pick_next = m_rem;
                    mod_started_next = 1'b0;
                end
            end
            S_FRD:
                faddr = FW'(pick_reg);
            S_FWAIT:
            begin
                pr_next = frd_reg[11:6];
                pc_next = frd_reg[5:0];
            end
            S_NREQ:
            begin
                inrange_next = n_in;
                caddr = n_in ? cidx(nr[5:0], nc[5:0]) : '0;
            end
            S_NWAIT:
            begin
                cand_next[dir_reg] = inrange_reg & crd_reg;
                dir_next = dir_reg + 2'd1;
            end
            S_MOD2:
            begin
                m_dvd = rdir_reg;
                m_dsr = {8'd0, kcnt};
                if (cand_reg != 4'd0)
                begin
                    if (!mod_started_reg)
                    begin
                        m_start = 1'b1;
                        mod_started_next = 1'b1;
                    end
                    else if (!m_busy)
                    begin
                        dir_next = chosen;
                        mod_started_next = 1'b0;
                    end
                end
            end
            S_CARVE1:
            begin
                cwe = 1'b1;
                caddr = cidx(nr[5:0], nc[5:0]);
                crow_next = nr[5:0];
                ccol_next = nc[5:0];
                mrow_next = 6'((nr + {1'b0, pr_reg}) >> 1);
                mcol_next = 6'((nc + {1'b0, pc_reg}) >> 1);
                status_next = ST_CARVED;
                if (size_reg < FDEP)
                begin
                    fwe = 1'b1;
                    faddr = FW'(size_reg);
                    fwd = {nr[5:0], nc[5:0]};
                    size_next = size_reg + 11'd1;
                end
            end
            S_CARVE2:
            begin
                cwe = 1'b1;
                caddr = cidx(mrow_reg, mcol_reg);
            end
            S_RET1:
                faddr = FW'(size_reg - 11'd1);
            S_RET2:
            begin
                last_next = frd_reg;
                size_next = size_reg - 11'd1;
            end
            S_RET3:
            begin
                fwe = 1'b1;
                faddr = FW'(pick_reg);
                fwd = last_reg;
                status_next = (size_reg == 11'd0) ? ST_FINISHED : ST_RETIRED;
            end
            S_FIN1:
            begin
                cwe = 1'b1;
                caddr = cidx(G6 - 6'd3, 6'd1);
            end
            S_FIN2:
            begin
                cwe = 1'b1;
                caddr = cidx(6'd2, G6 - 6'd2);
            end
            S_OUT:
            begin
                if (ovalid_reg && m_axis_tready)
                    ovalid_next = 1'b0;
                else
                    ovalid_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            size_reg        <= 11'd1;
            clr_reg         <= '0;
            clr_row_reg     <= '0;
            clr_col_reg     <= '0;
            ovalid_reg      <= 1'b0;
            mod_started_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            size_reg        <= size_next;
            clr_reg         <= clr_next;
            clr_row_reg     <= clr_row_next;
            clr_col_reg     <= clr_col_next;
            ovalid_reg      <= ovalid_next;
            mod_started_reg <= mod_started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rpick_reg <= rpick_next; rdir_reg <= rdir_next;
        rrow_reg <= rrow_next; rcol_reg <= rcol_next;
        pick_reg <= pick_next; pr_reg <= pr_next; pc_reg <= pc_next;
        dir_reg <= dir_next; cand_reg <= cand_next; last_reg <= last_next;
        inrange_reg <= inrange_next;
        status_reg <= status_next; crow_reg <= crow_next; ccol_reg <= ccol_next;
        mrow_reg <= mrow_next; mcol_reg <= mcol_next; wall_reg <= wall_next;
    end

    // marks the sweep that follows reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            boot_reg <= 1'b1;
        else if (state_reg == S_CLEAR && clr_reg == CW'(CELLS - 1))
            boot_reg <= 1'b0;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {1'b0, wall_reg, size_reg, mcol_reg, mrow_reg,
                            ccol_reg, crow_reg, status_reg};

endmodule

// ----- bench/grid_maze_carver_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_maze_carver_tb
// self-checking bench for the growing tree maze carver
// ----------------------------------------------------------------------------
// drives restart, carving step, cell read and the spare action code over the
// input stream, predicts every result with a local model of the grid and the
// frontier, and compares each result transfer field by field. gaps of random
// length fall on both streams, and one long receiver hold-off stalls the input.
// ----------------------------------------------------------------------------
module grid_maze_carver_tb;
    import gmc_pkg::*;

    localparam int GRID    = 31;
    localparam int FDEPTH  = 1024;
    localparam int MIDPT   = ((GRID - 2) / 4) * 2 + 2;
    localparam int N_RAND  = 1300;
    localparam int WD_MAX  = 20000;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [5:0]  read_col;
        logic [5:0]  read_row;
        logic [15:0] rand_dir;
        logic [15:0] rand_pick;
        logic [1:0]  action;
    } cmd_t;

    typedef struct packed {
        logic        cell_wall;
        logic [10:0] frontier_count;
        logic [5:0]  mid_col;
        logic [5:0]  mid_row;
        logic [5:0]  cell_col;
        logic [5:0]  cell_row;
        logic [2:0]  status;
    } res_t;

    typedef struct {
        cmd_t cmd;
        logic chk;
        res_t res;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    // grid and frontier mirror
    bit          wall_map [GRID][GRID];
    logic [11:0] front_pts [FDEPTH];
    int          front_cnt;

    res_t expected_q [$];
    int   fail_cnt = 0;
    int   n_res = 0;
    int   n_carve = 0;
    int   n_finish = 0;
    int   n_read = 0;
    int   idle_cyc = 0;
    bit   long_hold = 1'b0;

    grid_maze_carver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_grid();
        for (int r = 0; r < GRID; r++)
            for (int c = 0; c < GRID; c++)
                wall_map[r][c] = !(r == 0 || c == 0 || r == GRID - 1 || c == GRID - 1);
        for (int i = 0; i < FDEPTH; i++)
            front_pts[i] = '0;
        wall_map[MIDPT][MIDPT] = 1'b0;
        front_pts[0] = {6'(MIDPT), 6'(MIDPT)};
        front_cnt = 1;
    endfunction

    function automatic bit wall_at(int r, int c);
        if (r < 0 || c < 0 || r >= GRID || c >= GRID)
            return 1'b0;
        return wall_map[r][c];
    endfunction

    function automatic void open_at(int r, int c);
        if (r >= 0 && c >= 0 && r < GRID && c < GRID)
            wall_map[r][c] = 1'b0;
    endfunction

    function automatic res_t carve_result(cmd_t cmd);
        res_t o;
        int   cr [4];
        int   cc [4];
        int   k;
        int   pick;
        int   pr;
        int   pc;
        int   ch;
        int   dr [4] = '{-2, 0, 2, 0};
        int   dc [4] = '{0, -2, 0, 2};
        o = '0;
        o.status = ST_DONE;
        case (cmd.action)
            ACT_RESTART: clear_grid();
            ACT_READ:
                if (cmd.read_row < GRID && cmd.read_col < GRID)
                    o.cell_wall = wall_map[cmd.read_row][cmd.read_col];
            ACT_STEP:
                if (front_cnt == 0)
                    o.status = ST_ALREADY;
                else
                begin
                    k = 0;
                    pick = int'(cmd.rand_pick) % front_cnt;
                    pr = front_pts[pick][11:6];
                    pc = front_pts[pick][5:0];
                    for (int d = 0; d < 4; d++)
                        if (wall_at(pr + dr[d], pc + dc[d]))
                        begin
                            cr[k] = pr + dr[d];
                            cc[k] = pc + dc[d];
                            k++;
                        end
                    if (k == 0)
                    begin
                        front_pts[pick] = front_pts[front_cnt - 1];
                        front_cnt--;
                        if (front_cnt == 0)
                        begin
                            open_at(GRID - 3, 1);
                            open_at(2, GRID - 2);
                            o.status = ST_FINISHED;
                        end
                        else
                            o.status = ST_RETIRED;
                    end
                    else
                    begin
                        ch = int'(cmd.rand_dir) % k;
                        open_at(cr[ch], cc[ch]);
                        open_at((cr[ch] + pr) / 2, (cc[ch] + pc) / 2);
                        if (front_cnt < FDEPTH)
                        begin
                            front_pts[front_cnt] = {6'(cr[ch]), 6'(cc[ch])};
                            front_cnt++;
                        end
                        o.status = ST_CARVED;
                        o.cell_row = 6'(cr[ch]);
                        o.cell_col = 6'(cc[ch]);
                        o.mid_row = 6'((cr[ch] + pr) / 2);
                        o.mid_col = 6'((cc[ch] + pc) / 2);
                    end
                end
            default: ;
        endcase
        o.frontier_count = 11'(front_cnt);
        return o;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // sends one command; the result is predicted at acceptance
    task automatic send_cmd(cmd_t cmd, logic chk, res_t want);
        res_t exp_r;
        int   gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= 48'(cmd);
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        exp_r = carve_result(cmd);
        expected_q.push_back(chk ? want : exp_r);
    endtask

    function automatic cmd_t rand_cmd(int p);
        cmd_t c;
        c.rand_pick = 16'($urandom);
        c.rand_dir  = 16'($urandom);
        c.read_row  = 6'($urandom_range(0, 63));
        c.read_col  = 6'($urandom_range(0, 63));
        if (p < 2)
            c.action = ACT_RESTART;
        else if (p < 80)
            c.action = ACT_STEP;
        else if (p < 97)
        begin
            c.action = ACT_READ;
            if (p < 93)
            begin
                c.read_row = 6'($urandom_range(0, GRID - 1));
                c.read_col = 6'($urandom_range(0, GRID - 1));
            end
        end
        else
            c.action = ACT_SPARE;
        return c;
    endfunction

    // receiver: random stalls plus one long hold-off
    initial
    begin
        int g;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_hold && n_res == 300)
            begin
                long_hold = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            g = (n_res > 600 && n_res < 700) ? 0 : gap_len();
            if (g > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready))
                @(posedge clk);
            m_axis_tready <= 1'b0;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = res_t'(m_axis_tdata[38:0]);
            n_res++;
            if (expected_q.size() == 0)
            begin
                $error("result transfer with nothing expected: %h", got);
                fail_cnt++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.status == ST_CARVED)
                    n_carve++;
                if (got.status == ST_FINISHED)
                    n_finish++;
                if (got.status != want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    fail_cnt++;
                end
                if (got.cell_row != want.cell_row)
                begin
                    $error("cell_row: expected %0d, actual %0d", want.cell_row,
                        got.cell_row);
                    fail_cnt++;
                end
                if (got.cell_col != want.cell_col)
                begin
                    $error("cell_col: expected %0d, actual %0d", want.cell_col,
                        got.cell_col);
                    fail_cnt++;
                end
                if (got.mid_row != want.mid_row)
                begin
                    $error("mid_row: expected %0d, actual %0d", want.mid_row, got.mid_row);
                    fail_cnt++;
                end
                if (got.mid_col != want.mid_col)
                begin
                    $error("mid_col: expected %0d, actual %0d", want.mid_col, got.mid_col);
                    fail_cnt++;
                end
                if (got.frontier_count != want.frontier_count)
                begin
                    $error("frontier_count: expected %0d, actual %0d",
                        want.frontier_count, got.frontier_count);
                    fail_cnt++;
                end
                if (got.cell_wall != want.cell_wall)
                begin
                    $error("cell_wall: expected %0d, actual %0d", want.cell_wall,
                        got.cell_wall);
                    fail_cnt++;
                end
                if (m_axis_tdata[39] !== 1'b0)
                begin
                    $error("zero fill: expected 0, actual %b", m_axis_tdata[39]);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WD_MAX)
        begin
            $display("watchdog expired with %0d results outstanding", expected_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        row_t dir_tab [$];
        row_t rw;
        cmd_t c;
        int   in_maze;
        clear_grid();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed table: reset state, extremes, all actions, special cases
        rw.chk = 1'b0; rw.res = '0;
        rw.cmd = '{read_col: 6'(MIDPT), read_row: 6'(MIDPT), rand_dir: 0, rand_pick: 0,
                   action: ACT_READ};
        rw.chk = 1'b1; rw.res = '{cell_wall: 0, frontier_count: 1, default: 0};
        rw.res.status = ST_DONE;
        dir_tab.push_back(rw);
        rw.cmd = '{read_col: 1, read_row: 1, rand_dir: 0, rand_pick: 0, action: ACT_READ};
        rw.res.cell_wall = 1'b1;
        dir_tab.push_back(rw);
        rw.cmd = '{read_col: 0, read_row: 0, rand_dir: 0, rand_pick: 0, action: ACT_READ};
        rw.res.cell_wall = 1'b0;
        dir_tab.push_back(rw);
        // outside the grid reads as open
        rw.cmd = '{read_col: 63, read_row: 63, rand_dir: 16'hffff, rand_pick: 16'hffff,
                   action: ACT_READ};
        dir_tab.push_back(rw);
        rw.cmd = '{read_col: 5, read_row: 6'(GRID), rand_dir: 0, rand_pick: 0,
                   action: ACT_READ};
        dir_tab.push_back(rw);
        // spare action code changes nothing
        rw.cmd = '{read_col: 63, read_row: 63, rand_dir: 16'hffff, rand_pick: 16'hffff,
                   action: ACT_SPARE};
        dir_tab.push_back(rw);
        rw.chk = 1'b0;
        for (int i = 0; i < 10; i++)
        begin
            rw.cmd = '{read_col: 0, read_row: 0, rand_dir: (i % 2) ? 16'hffff : 16'h0,
                       rand_pick: (i % 3) ? 16'hffff : 16'h0, action: ACT_STEP};
            dir_tab.push_back(rw);
        end
        rw.cmd = '{read_col: 0, read_row: 0, rand_dir: 0, rand_pick: 0, action: ACT_RESTART};
        rw.chk = 1'b1; rw.res = '{frontier_count: 1, default: 0};
        rw.res.status = ST_DONE;
        dir_tab.push_back(rw);
        rw.cmd = '{read_col: 6'(GRID - 1), read_row: 6'(GRID - 1), rand_dir: 0,
                   rand_pick: 0, action: ACT_READ};
        dir_tab.push_back(rw);
        foreach (dir_tab[i])
            send_cmd(dir_tab[i].cmd, dir_tab[i].chk, dir_tab[i].res);

        // random part: long runs of steps carve whole mazes to completion
        for (int n = 0; n < N_RAND; n++)
        begin
            c = rand_cmd($urandom_range(0, 99));
            // once finished, restart now and then so several mazes get carved
            if (front_cnt == 0 && $urandom_range(0, 3) == 0)
                c.action = ACT_RESTART;
            send_cmd(c, 1'b0, '0);
        end
        // run steps until the current maze finishes, then try an extra step
        in_maze = 0;
        while (front_cnt != 0 && in_maze < 2000)
        begin
            c = rand_cmd(50);
            send_cmd(c, 1'b0, '0);
            in_maze++;
        end
        c = rand_cmd(50);
        send_cmd(c, 1'b0, '0);
        c.action = ACT_READ; c.read_row = 6'(GRID - 3); c.read_col = 6'd1;
        send_cmd(c, 1'b0, '0);
        s_axis_tvalid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d results: %0d carves, %0d mazes finished, long stall %0d",
            n_res, n_carve, n_finish, long_hold);
        if (fail_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
